>>> hdl/gap_buffer_text_editor_assert.svh
// Assertion macros shared by the gap buffer editor.
`ifndef GAP_BUFFER_TEXT_EDITOR_ASSERT_SVH
`define GAP_BUFFER_TEXT_EDITOR_ASSERT_SVH
// Assert that a property holds at every clock edge outside reset.
`define GBE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert that a property holds at every clock edge, including reset.
`define GBE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> hdl/gbe_pkg.sv
// ----------------------------------------------------------------------------
// Gap buffer editor package
// Shared constants and types for the gap buffer text editor.
// ----------------------------------------------------------------------------
package gbe_pkg;
   localparam int CAPACITY_DEFAULT = 1024;
   localparam int CP_W = 21;
   localparam int KIND_W = 3;
   localparam int POS_W = 10;
   localparam int LEN_W = 11;
   localparam int STATUS_W = 2;
   localparam int TAB_W = 5;
   localparam logic [TAB_W-1:0] TAB_RESET = 5'd4;

   localparam logic [CP_W-1:0] CP_TAB = 21'd9;
   localparam logic [CP_W-1:0] CP_NEWLINE = 21'd10;
   localparam logic [CP_W-1:0] CP_SPACE = 21'd32;

   typedef enum logic [KIND_W-1:0] {
      KIND_LEFT = 3'd0, KIND_RIGHT = 3'd1, KIND_UP = 3'd2, KIND_DOWN = 3'd3,
      KIND_INSERT = 3'd4, KIND_DELETE = 3'd5, KIND_READ = 3'd6, KIND_NONE = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK = 2'd0, STATUS_FULL = 2'd1, STATUS_RANGE = 2'd2
   } status_type;
endpackage

>>> hdl/gbe_req_if.sv
// ----------------------------------------------------------------------------
// Gap buffer editor request channel
// Valid and ready handshake carrying one editor command.
// ----------------------------------------------------------------------------
interface gbe_req_if import gbe_pkg::*; ();
   logic valid;
   logic ready;
   logic [KIND_W-1:0] kind;
   logic [CP_W-1:0] code_point;
   logic [POS_W-1:0] position;
   modport source (output valid, kind, code_point, position, input ready);
   modport sink (input valid, kind, code_point, position, output ready);
endinterface

>>> hdl/gbe_rsp_if.sv
// ----------------------------------------------------------------------------
// Gap buffer editor response channel
// Valid and ready handshake carrying one command result.
// ----------------------------------------------------------------------------
interface gbe_rsp_if import gbe_pkg::*; ();
   logic valid;
   logic ready;
   logic [CP_W-1:0] read_data;
   logic [LEN_W-1:0] cursor;
   logic [LEN_W-1:0] text_length;
   logic [STATUS_W-1:0] status;
   modport source (output valid, read_data, cursor, text_length, status, input ready);
   modport sink (input valid, read_data, cursor, text_length, status, output ready);
endinterface

>>> hdl/gbe_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module gbe_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/gap_buffer_text_editor.sv
// ----------------------------------------------------------------------------
// Gap buffer text editor
// Holds text in a gap buffer in one RAM and executes cursor and edit requests.
// ----------------------------------------------------------------------------
// Requests arrive on req (kind, code_point, position) and each produces one
// response on rsp carrying read data, cursor, text length and status. The tab
// size register is written through csr_wr_en and csr_wr_data; the user must
// write it only while idle, as the block itself does not enforce this. One
// request is worked on at a time. Left and right each do a RAM read and a
// write back through the single port. Up and down walk the text through that
// port, reading characters to scan and moving them, so their time grows with
// line length. A tab first reduces the cursor position modulo the tab size, one
// cursor bit per step, then writes one space per cycle. Reset clears the gap to
// span the whole RAM and sets the tab size to four; the RAM contents need no
// clearing. When the receiver stalls, the response waits in its output register
// and the next request is taken only once the response has gone.
// ----------------------------------------------------------------------------
`include "gap_buffer_text_editor_assert.svh"
module gap_buffer_text_editor import gbe_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [TAB_W-1:0]  csr_wr_data,
   gbe_req_if.sink           req,
   gbe_rsp_if.source         rsp
);
   localparam int AW = $clog2(CAPACITY);
   localparam int GW = $clog2(CAPACITY + 1);
   localparam int BW = $clog2(GW);
   localparam logic [GW-1:0] CAP = GW'(CAPACITY);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b0_0000_0001, ST_MOVE_RD = 9'b0_0000_0010,
      ST_MOVE_WR = 9'b0_0000_0100, ST_SCAN_RD = 9'b0_0000_1000,
      ST_SCAN_CHK = 9'b0_0001_0000, ST_TAB = 9'b0_0010_0000,
      ST_READ = 9'b0_0100_0000, ST_RESP = 9'b0_1000_0000,
      ST_TAB_MOD = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [GW-1:0] gs_ff, gs_in, ge_ff, ge_in, target_ff, target_in, p_ff, p_in;
   logic [TAB_W-1:0] tab_ff, tab_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [CP_W-1:0] data_ff, data_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TAB_W-1:0] spaces_ff, spaces_in;
   logic [TAB_W-1:0] rem_ff, rem_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic moving_ff, moving_in;
   logic [TAB_W-1:0] ts, tab_need;
   logic [TAB_W:0] mod_shift, mod_next;
   logic [GW-1:0] room, len, phys;
   logic wr_en;
   logic [AW-1:0] addr;
   logic [CP_W-1:0] wr_data, rd_data;

   gbe_ram #(.WIDTH(CP_W), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(rd_data)
   );

   assign ts = (tab_ff == '0) ? TAB_W'(1) : tab_ff;
   assign mod_shift = {rem_ff, gs_ff[bit_ff]};
   assign mod_next = (mod_shift >= {1'b0, ts}) ? mod_shift - {1'b0, ts} : mod_shift;
   assign tab_need = ts - mod_next[TAB_W-1:0];
   assign room = ge_ff - gs_ff;
   assign len = gs_ff + (CAP - ge_ff);
   assign phys = (p_ff < gs_ff) ? p_ff : p_ff + room;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_RESP);
   assign rsp.read_data = data_ff;
   assign rsp.cursor = LEN_W'(gs_ff);
   assign rsp.text_length = LEN_W'(len);
   assign rsp.status = status_ff;

   always_comb begin
      state_in = state_ff; gs_in = gs_ff; ge_in = ge_ff; target_in = target_ff;
      p_in = p_ff; tab_in = csr_wr_en ? csr_wr_data : tab_ff; kind_in = kind_ff;
      data_in = data_ff; status_in = status_ff; spaces_in = spaces_ff;
      rem_in = rem_ff; bit_in = bit_ff;
      moving_in = moving_ff; wr_en = 1'b0; addr = '0; wr_data = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               kind_in = req.kind; data_in = '0; status_in = STATUS_OK;
               moving_in = 1'b0; state_in = ST_RESP;
               case (req.kind)
                  KIND_LEFT: if (gs_ff != '0) begin
                     target_in = gs_ff - GW'(1); state_in = ST_MOVE_RD;
                  end
                  KIND_RIGHT: if (ge_ff != CAP) begin
                     target_in = gs_ff + GW'(1); state_in = ST_MOVE_RD;
                  end
                  KIND_UP: begin
                     target_in = '0; p_in = gs_ff;
                     if (gs_ff != '0) state_in = ST_SCAN_RD;
                  end
                  KIND_DOWN: begin
                     target_in = len; p_in = gs_ff;
                     if (gs_ff != len) state_in = ST_SCAN_RD;
                  end
                  KIND_INSERT: begin
                     if (req.code_point == CP_TAB) begin
                        rem_in = '0; bit_in = BW'(GW - 1); state_in = ST_TAB_MOD;
                     end else if (room == '0) status_in = STATUS_FULL;
                     else begin
                        wr_en = 1'b1; addr = AW'(gs_ff); wr_data = req.code_point;
                        gs_in = gs_ff + GW'(1);
                     end
                  end
                  KIND_DELETE: if (gs_ff != '0) gs_in = gs_ff - GW'(1);
                  KIND_READ: begin
                     if (GW'(req.position) < len) begin
                        p_in = GW'(req.position); state_in = ST_READ;
                     end else status_in = STATUS_RANGE;
                  end
                  default: ;
               endcase
            end
         end
         ST_TAB_MOD: begin
            rem_in = mod_next[TAB_W-1:0];
            if (bit_ff == '0) begin
               if (room < GW'(tab_need)) begin
                  status_in = STATUS_FULL; state_in = ST_RESP;
               end else begin
                  spaces_in = tab_need; state_in = ST_TAB;
               end
            end else bit_in = bit_ff - BW'(1);
         end
         ST_MOVE_RD: begin
            addr = (target_ff < gs_ff) ? AW'(gs_ff - GW'(1)) : AW'(ge_ff);
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            wr_en = 1'b1; wr_data = rd_data;
            if (target_ff < gs_ff) begin
               addr = AW'(ge_ff - GW'(1));
               gs_in = gs_ff - GW'(1); ge_in = ge_ff - GW'(1);
            end else begin
               addr = AW'(gs_ff);
               gs_in = gs_ff + GW'(1); ge_in = ge_ff + GW'(1);
            end
            if (gs_in == target_ff || ge_in == CAP) state_in = ST_RESP;
            else state_in = ST_MOVE_RD;
         end
         ST_SCAN_RD: begin
            if (kind_ff == KIND_UP) begin
               p_in = p_ff - GW'(1);
               addr = AW'(p_in);
            end else addr = AW'(phys);
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (rd_data == CP_NEWLINE) begin
               target_in = (kind_ff == KIND_UP) ? p_ff : p_ff + GW'(1);
               state_in = ST_MOVE_RD;
            end else if (kind_ff == KIND_UP) begin
               state_in = (p_ff == '0) ? ST_MOVE_RD : ST_SCAN_RD;
            end else begin
               p_in = p_ff + GW'(1);
               state_in = (p_in == len) ? ST_MOVE_RD : ST_SCAN_RD;
            end
            if (state_in == ST_MOVE_RD && target_in == gs_ff) state_in = ST_RESP;
         end
         ST_TAB: begin
            wr_en = 1'b1; addr = AW'(gs_ff); wr_data = CP_SPACE;
            gs_in = gs_ff + GW'(1); spaces_in = spaces_ff - TAB_W'(1);
            if (spaces_in == '0) state_in = ST_RESP;
         end
         ST_READ: begin
            if (!moving_ff) begin
               addr = AW'(phys); moving_in = 1'b1;
            end else begin
               data_in = rd_data; state_in = ST_RESP;
            end
         end
         ST_RESP: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; gs_ff <= '0; ge_ff <= CAP; tab_ff <= TAB_RESET;
      end else begin
         state_ff <= state_in; gs_ff <= gs_in; ge_ff <= ge_in; tab_ff <= tab_in;
      end
      target_ff <= target_in; p_ff <= p_in; kind_ff <= kind_in; data_ff <= data_in;
      status_ff <= status_in; spaces_ff <= spaces_in; moving_ff <= moving_in;
      rem_ff <= rem_in; bit_ff <= bit_in;
   end

   `GBE_ASSERT(a_gap_order, clock, reset, gs_ff <= ge_ff && ge_ff <= CAP, "gap bounds broken")
   `GBE_ASSERT(a_one_owner, clock, reset, !(req.ready && rsp.valid), "request and response overlap")
   `GBE_ASSERT(a_resp_holds, clock, reset, rsp.valid && !rsp.ready |=> rsp.valid && $stable(gs_ff), "response changed while stalled")
endmodule
